// ===== design/positional_insert_delete_list_defines.svh =====
// Assertion macros for the positional list block.
`ifndef POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only out of reset.
`define PIDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PIDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIDL_ASSERT(lbl, prop, msg)
`define PIDL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/pidl_pkg.sv =====
package pidl_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int MODE_W         = 2;
  localparam int POS_W          = 8;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 8;
  localparam int GROUP_SIZE     = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Per-cell control decoded at the top and fanned out along the chain.
  typedef struct packed {
    logic load;        // take the new word
    logic take_left;   // shift up: take lower neighbor
    logic take_right;  // shift down: take upper neighbor
    logic rd_sel;      // drive own word onto the read tree
  } cell_ctl_t;

endpackage

// ===== design/pidl_cell.sv =====
module pidl_cell #(
  parameter int WORD_WIDTH = pidl_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  pidl_pkg::cell_ctl_t   ctl,
  input  logic [WORD_WIDTH-1:0] din,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  output logic [WORD_WIDTH-1:0] word,
  output logic [WORD_WIDTH-1:0] rd_word
);
  import pidl_pkg::*;

  logic [WORD_WIDTH-1:0] word_r, word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.load) begin
      word_nxt = din;
    end else if (ctl.take_left) begin
      word_nxt = left_word;
    end else if (ctl.take_right) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_word = ctl.rd_sel ? word_r : '0;

endmodule

// ===== design/pidl_rd_tree.sv =====
module pidl_rd_tree #(
  parameter int DEPTH      = pidl_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = pidl_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic [WORD_WIDTH-1:0] words [DEPTH],
  output logic [WORD_WIDTH-1:0] rd_word
);
  import pidl_pkg::*;

  localparam int NGRP = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [WORD_WIDTH-1:0] grp_r   [NGRP];
  logic [WORD_WIDTH-1:0] grp_nxt [NGRP];
  logic [WORD_WIDTH-1:0] rd_r, rd_nxt;

  // At most one cell drives a nonzero word, so OR acts as the select.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | words[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_comb begin
    rd_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_nxt = rd_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    rd_r  <= rd_nxt;
  end

  assign rd_word = rd_r;

endmodule

// ===== design/positional_insert_delete_list.sv =====
// Result path: an accepted word's status and count are registered in
// a_*_r and then out_*_r, in step with the read tree; out_valid is high
// for one cycle per word. Throughput: one word per cycle; busy never
// rises. Inserts and deletes shift all cells from the given position up
// together; reads go through a two-stage registered OR tree over the
// cells. Reset: synchronous, clears the fill count and the valid bits.
`include "positional_insert_delete_list_defines.svh"

module positional_insert_delete_list #(
  parameter int DEPTH      = pidl_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = pidl_pkg::WORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pidl_pkg::MODE_W-1:0]         in_mode,
  input  logic [pidl_pkg::POS_W-1:0]          in_position,
  input  logic signed [pidl_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  output logic [pidl_pkg::STATUS_W-1:0]       out_status,
  output logic [pidl_pkg::COUNT_W-1:0]        out_count,
  output logic signed [pidl_pkg::VALUE_W-1:0] out_read_value
);
  import pidl_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = CNT_W + POS_W + 1;

  logic                  accept;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CMP_W-1:0]      cnt_x, pos_x, k_x;
  logic [STATUS_W-1:0]   status_c;
  logic                  ins_c, del_c, rd_c;
  logic                  ins_ok, del_ok, rd_ok;
  logic [WORD_WIDTH-1:0] din;
  logic [WORD_WIDTH+VALUE_W-1:0] din_ext;
  logic [CNT_W+COUNT_W-1:0]      cnt_wide;

  logic                  a_vld_r;
  logic [STATUS_W-1:0]   a_status_r;
  logic [COUNT_W-1:0]    a_count_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  cell_ctl_t             ctl        [DEPTH];
  logic [WORD_WIDTH-1:0] words      [DEPTH];
  logic [WORD_WIDTH-1:0] rd_words   [DEPTH];
  logic [WORD_WIDTH-1:0] left_word  [DEPTH];
  logic [WORD_WIDTH-1:0] right_word [DEPTH];
  logic [WORD_WIDTH-1:0] rd_word;
  logic [WORD_WIDTH+VALUE_W-1:0] rd_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign cnt_x = CMP_W'(cnt_r);
  assign pos_x = CMP_W'(in_position);
  assign k_x   = pos_x - CMP_W'(1);

  always_comb begin
    status_c = ST_OK;
    ins_c    = 1'b0;
    del_c    = 1'b0;
    rd_c     = 1'b0;
    case (in_mode)
      MODE_INSERT: begin
        if (cnt_x == CMP_W'(DEPTH)) begin
          status_c = ST_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          status_c = ST_BAD_POS;
        end else begin
          ins_c = 1'b1;
        end
      end
      MODE_DELETE, MODE_READ: begin
        if (cnt_x == '0) begin
          status_c = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          status_c = ST_BAD_POS;
        end else if (in_mode == MODE_DELETE) begin
          del_c = 1'b1;
        end else begin
          rd_c = 1'b1;
        end
      end
      default: begin
        status_c = ST_BAD_POS;
      end
    endcase
  end

  assign ins_ok = accept && ins_c;
  assign del_ok = accept && del_c;
  assign rd_ok  = accept && rd_c;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (del_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign cnt_wide = {{COUNT_W{1'b0}}, cnt_nxt};
  assign din_ext  = {{WORD_WIDTH{in_value[VALUE_W-1]}}, in_value};
  assign din      = din_ext[WORD_WIDTH-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

    assign ctl[i].load       = ins_ok && (IDX == k_x);
    assign ctl[i].take_left  = ins_ok && (IDX > k_x);
    assign ctl[i].take_right = del_ok && (IDX >= k_x);
    assign ctl[i].rd_sel     = rd_ok && (IDX == k_x);

    if (i == 0) begin : g_first
      assign left_word[i] = '0;
    end else begin : g_mid_l
      assign left_word[i] = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_word[i] = '0;
    end else begin : g_mid_r
      assign right_word[i] = words[i+1];
    end

    pidl_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .din       (din),
      .left_word (left_word[i]),
      .right_word(right_word[i]),
      .word      (words[i]),
      .rd_word   (rd_words[i])
    );
  end

  pidl_rd_tree #(
    .DEPTH     (DEPTH),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_rd_tree (
    .clk    (clk),
    .words  (rd_words),
    .rd_word(rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      a_vld_r     <= accept;
      out_valid_r <= a_vld_r;
    end
  end

  // Result word payload follows the read tree timing.
  always_ff @(posedge clk) begin
    a_status_r   <= status_c;
    a_count_r    <= cnt_wide[COUNT_W-1:0];
    out_status_r <= a_status_r;
    out_count_r  <= a_count_r;
  end

  assign rd_ext         = {{VALUE_W{rd_word[WORD_WIDTH-1]}}, rd_word};
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_read_value = rd_ext[VALUE_W-1:0];

  `PIDL_ASSERT(a_latency, accept |=> ##1 out_valid, "accepted word gave no result")
  `PIDL_ASSERT(a_cnt_hold, !accept |=> $stable(cnt_r), "fill count moved while idle")
  `PIDL_ASSERT(a_rd_zero, out_valid && out_status != ST_OK |-> out_read_value == '0, "data on error")
  `PIDL_ASSERT_ALWAYS(a_cnt_max, !rst_n || cnt_r <= CNT_W'(DEPTH), "fill count above depth")

endmodule
